>>> rtl/core/pid_duty_controller_defines.svh
// ---------------------------------------------------------------------------
// pid_duty_controller_defines.svh
// Assertion macros shared by the pid duty controller rtl.
// ---------------------------------------------------------------------------
`ifndef PID_DUTY_CONTROLLER_DEFINES_SVH
`define PID_DUTY_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pdc assertion failed");
// next-cycle implication
`define PDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pdc assertion failed");
`else
`define PDC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/pdc_pkg.sv
// ---------------------------------------------------------------------------
// pdc_pkg
// Widths, limits, codes and shared types of the pid duty controller.
// ---------------------------------------------------------------------------
package pdc_pkg;

    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int RATE_W  = 16;
    localparam int DUTY_W  = 10;
    localparam int INTEG_W = 22;
    localparam int DIFF_W  = ERR_W + 1;

    // shared multiplier operands and product
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W;

    // integral term before division: |gain * integral| < 2**36
    localparam int DIVD_W    = 37;
    localparam int DIV_STEPS = DIVD_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [INTEG_W:0] INTEGRAL_LIMIT = 23'sd2000000;
    localparam logic [DUTY_W-1:0]       DUTY_MAX       = 10'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP   = 2'd0,
        CFG_GAIN_INTEG  = 2'd1,
        CFG_GAIN_DERIV  = 2'd2,
        CFG_UPDATE_RATE = 2'd3
    } t_cfg_idx;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MI   = 8'b0000_0010,
        S_MP   = 8'b0000_0100,
        S_MR   = 8'b0000_1000,
        S_MD   = 8'b0001_0000,
        S_MA   = 8'b0010_0000,
        S_WDIV = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/core/pdc_in_if.sv
// ---------------------------------------------------------------------------
// pdc_in_if
// Error sample channel: valid, ready and one signed error sample.
// ---------------------------------------------------------------------------
interface pdc_in_if
    import pdc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

>>> rtl/core/pdc_out_if.sv
// ---------------------------------------------------------------------------
// pdc_out_if
// Duty result channel: valid, ready and one duty value.
// ---------------------------------------------------------------------------
interface pdc_out_if
    import pdc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;

    modport source (output valid, output duty, input ready);
    modport sink   (input valid, input duty, output ready);
endinterface

>>> rtl/core/pdc_mul.sv
// ---------------------------------------------------------------------------
// pdc_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module pdc_mul
    import pdc_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/pdc_div.sv
// ---------------------------------------------------------------------------
// pdc_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module pdc_div
    import pdc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIVD_W-1:0] i_dividend,
    input  logic [RATE_W-1:0]        i_divisor,
    output logic signed [DIVD_W-1:0] o_quot,
    output t_div_stat                o_stat
);

    logic [DIV_STEPS-1:0] r_q;
    logic [RATE_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic                 r_busy;
    logic                 r_done;

    logic [DIVD_W-1:0]    w_mag;
    logic [RATE_W:0]      w_shift;
    logic [RATE_W:0]      w_trial;
    logic                 w_ge;
    logic [DIVD_W-1:0]    w_q_ext;

    // magnitude never reaches 2**36, so the top bit drops
    assign w_mag   = i_dividend[DIVD_W-1] ? DIVD_W'(-i_dividend) : DIVD_W'(i_dividend);
    assign w_shift = {r_rem, r_q[DIV_STEPS-1]};
    assign w_ge    = (w_shift >= {1'b0, i_divisor});
    assign w_trial = w_shift - {1'b0, i_divisor};
    assign w_q_ext = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag[DIV_STEPS-1:0];
            r_rem <= '0;
            r_neg <= i_dividend[DIVD_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_STEPS-2:0], w_ge};
            r_rem <= w_ge ? w_trial[RATE_W-1:0] : w_shift[RATE_W-1:0];
        end
    end

    assign o_quot      = r_neg ? $signed(-w_q_ext) : $signed(w_q_ext);
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> rtl/core/pid_duty_controller.sv
// ---------------------------------------------------------------------------
// pid_duty_controller
// PID controller with clamped integral and saturated duty result.
// ---------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  i_sample   in   valid / ready    error_sample  s16
//  o_result   out  valid / ready    duty          u10 (0..1000)
//  cfg        in   i_cfg_we         i_cfg_idx, i_cfg_data
//
//  one sample at a time: the next sample beat is taken in S_IDLE only, after
//  the multiply states and the 36 one-bit steps of the restoring divider
//  a zero update rate skips the divider
//  synchronous reset: gains 0, update rate 1, integral and previous error 0
//  a finished result waits in the output register; the next beat is taken
//  meanwhile and its result waits for that register to free up
// ---------------------------------------------------------------------------
`include "pid_duty_controller_defines.svh"

module pid_duty_controller
    import pdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdc_in_if.sink                i_sample,
    pdc_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic signed [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic        [RATE_W-1:0]  r_rate;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [ACC_W-1:0]   r_acc;
    logic [DUTY_W-1:0]         r_duty;
    logic                      r_out_valid;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DIVD_W-1:0]  w_quot;
    t_div_stat                 w_div_stat;
    logic                      w_div_start;

    logic                      w_in_beat;
    logic                      w_out_load;
    logic signed [INTEG_W:0]   w_integ_sum;
    logic signed [INTEG_W-1:0] w_integ_clamp;
    logic signed [ACC_W-9:0]   w_shifted;
    logic [DUTY_W-1:0]         w_duty;

    assign w_in_beat  = i_sample.valid && i_sample.ready;
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || o_result.ready);

    // integral update with clamp
    assign w_integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(i_sample.error_sample);
    always_comb begin
        if (w_integ_sum > INTEGRAL_LIMIT) begin
            w_integ_clamp = INTEG_W'(INTEGRAL_LIMIT);
        end else if (w_integ_sum < -INTEGRAL_LIMIT) begin
            w_integ_clamp = INTEG_W'(-INTEGRAL_LIMIT);
        end else begin
            w_integ_clamp = w_integ_sum[INTEG_W-1:0];
        end
    end

    // floor shift then saturate
    assign w_shifted = r_acc[ACC_W-1:8];
    always_comb begin
        if (w_shifted <= 0) begin
            w_duty = '0;
        end else if (w_shifted >= (ACC_W-8)'(DUTY_MAX)) begin
            w_duty = DUTY_MAX;
        end else begin
            w_duty = w_shifted[DUTY_W-1:0];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_MI: begin
                w_mul_a = MUL_A_W'(r_gain_i);
                w_mul_b = MUL_B_W'(r_integ);
            end
            S_MP: begin
                w_mul_a = MUL_A_W'(r_gain_p);
                w_mul_b = MUL_B_W'(r_err);
            end
            S_MR: begin
                w_mul_a = $signed({1'b0, r_rate});
                w_mul_b = MUL_B_W'(r_diff);
            end
            S_MD: begin
                w_mul_a = MUL_A_W'(r_gain_d);
                w_mul_b = w_prod[MUL_B_W-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_div_start = (r_state == S_MP) && (r_rate != '0);

    pdc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    pdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod[DIVD_W-1:0]),
        .i_divisor  (r_rate),
        .o_quot     (w_quot),
        .o_stat     (w_div_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_beat) n_state = S_MI;
            S_MI:   n_state = S_MP;
            S_MP:   n_state = S_MR;
            S_MR:   n_state = S_MD;
            S_MD:   n_state = S_MA;
            S_MA:   n_state = S_WDIV;
            S_WDIV: if (r_rate == '0 || w_div_stat.done) n_state = S_FIN;
            S_FIN:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_rate      <= RATE_W'(1);
            r_integ     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAIN_PROP:   r_gain_p <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_GAIN_INTEG:  r_gain_i <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_GAIN_DERIV:  r_gain_d <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_UPDATE_RATE: r_rate   <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_beat) begin
                r_integ <= w_integ_clamp;
                r_prev  <= i_sample.error_sample;
            end
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_err  <= i_sample.error_sample;
            r_diff <= DIFF_W'(i_sample.error_sample) - DIFF_W'(r_prev);
        end
        case (r_state)
            S_MR:   r_acc <= w_prod;
            S_MA:   r_acc <= r_acc + w_prod;
            S_WDIV: if (r_rate != '0 && w_div_stat.done) r_acc <= r_acc + ACC_W'(w_quot);
            default: ;
        endcase
        if (w_out_load) begin
            r_duty <= w_duty;
        end
    end

    assign i_sample.ready = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.duty  = r_duty;

    `PDC_ASSERT_IMP(a_integ_bound, i_clk, i_rst_n, 1'b1,
        (r_integ <= INTEGRAL_LIMIT) && (r_integ >= -INTEGRAL_LIMIT))
    `PDC_ASSERT_NEXT(a_beat_starts, i_clk, i_rst_n, w_in_beat, r_state == S_MI)
    `PDC_ASSERT_IMP(a_div_busy_win, i_clk, i_rst_n, w_div_stat.busy,
        (r_state == S_MR) || (r_state == S_MD) || (r_state == S_MA) || (r_state == S_WDIV))
    `PDC_ASSERT_IMP(a_div_done_win, i_clk, i_rst_n, w_div_stat.done, r_state == S_WDIV)
    `PDC_ASSERT_IMP(a_duty_range, i_clk, i_rst_n, r_out_valid, r_duty <= DUTY_MAX)

endmodule

>>> sim/pdc_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pdc_checker
// Watches the sample, result and register ports of the pid duty controller,
// keeps its own copy of the gains, integral and previous error, predicts
// the duty value of every accepted sample and compares it in order with
// the accepted result beats.
// ---------------------------------------------------------------------------
module pdc_checker
    import pdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdc_in_if                     i_sample,
    pdc_out_if                    i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending
);

    localparam longint INTEG_LIM = INTEGRAL_LIMIT;
    localparam longint DUTY_TOP  = DUTY_MAX;

    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic        [RATE_W-1:0]  rate;
    logic signed [INTEG_W-1:0] integ_sum;
    logic signed [ERR_W-1:0]   prev_err;
    logic        [DUTY_W-1:0]  duty_due[$];

    // advances the controller state by one sample and returns its duty
    function automatic logic [DUTY_W-1:0] next_duty(input logic signed [ERR_W-1:0] err);
        longint e;
        longint acc;
        longint p_term;
        longint i_term;
        longint d_term;
        longint s;
        e   = err;
        acc = longint'(integ_sum) + e;
        if (acc > INTEG_LIM) begin
            acc = INTEG_LIM;
        end
        if (acc < -INTEG_LIM) begin
            acc = -INTEG_LIM;
        end
        integ_sum = acc[INTEG_W-1:0];

        p_term = longint'(kp) * e;
        // a zero rate kills both rate-dependent terms
        if (rate != '0) begin
            i_term = (longint'(ki) * acc) / longint'(rate);
        end else begin
            i_term = 0;
        end
        d_term = longint'(kd) * longint'(rate) * (e - longint'(prev_err));

        // arithmetic shift rounds toward minus infinity
        s = (p_term + i_term + d_term) >>> 8;
        if (s >= DUTY_TOP) begin
            s = DUTY_TOP;
        end
        if (s <= 0) begin
            s = 0;
        end
        prev_err = err;
        return s[DUTY_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [DUTY_W-1:0] want;
        if (!i_rst_n) begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            rate       = RATE_W'(1);
            integ_sum  = '0;
            prev_err   = '0;
            duty_due.delete();
            o_fail_cnt = 0;
            o_pending  = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAIN_PROP:   kp   = i_cfg_data;
                    CFG_GAIN_INTEG:  ki   = i_cfg_data;
                    CFG_GAIN_DERIV:  kd   = i_cfg_data;
                    CFG_UPDATE_RATE: rate = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (duty_due.size() == 0) begin
                    $error("duty beat with nothing pending: actual %0d", i_result.duty);
                    o_fail_cnt++;
                end else begin
                    want = duty_due.pop_front();
                    if (i_result.duty !== want) begin
                        $error("duty mismatch: expected %0d, actual %0d", want, i_result.duty);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                duty_due.push_back(next_duty(i_sample.error_sample));
            end
            o_pending = duty_due.size();
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives the pid duty controller with directed and random error samples
// over many gain and rate settings, with random stalls on both channels
// and one long result back-pressure stretch; the checker does the scoring.
// ---------------------------------------------------------------------------
module testbench;
    import pdc_pkg::*;

    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 152;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_cnt;
    int                    pending;
    int                    quiet_cycles;
    logic                  gap_en;
    logic                  stall_en;
    logic                  long_hold;

    pdc_in_if  smp ();
    pdc_out_if res ();

    pid_duty_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pdc_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .i_result   (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ends the run when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall bursts and the long hold-off on request
    initial begin : result_drain
        int gap;
        bit held;
        held      = 1'b0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !held) begin
                res.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                held = 1'b1;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                res.ready = 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(negedge i_clk);
            end
            res.ready = 1'b1;
        end
    end

    task automatic send_error(input logic [ERR_W-1:0] err);
        int gap;
        if (gap_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge i_clk);
        end
        smp.valid        = 1'b1;
        smp.error_sample = err;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        @(negedge i_clk);
        smp.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_gains(input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] i,
                             input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] r);
        wait_idle();
        write_reg(CFG_GAIN_PROP, p);
        write_reg(CFG_GAIN_INTEG, i);
        write_reg(CFG_GAIN_DERIV, d);
        write_reg(CFG_UPDATE_RATE, r);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    initial begin : stimulus
        logic [RATE_W-1:0] r;
        logic [ERR_W-1:0]  err;
        int                mode;
        logic              dir;

        i_rst_n          = 1'b0;
        smp.valid        = 1'b0;
        smp.error_sample = '0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_GAIN_PROP;
        cfg_data         = '0;
        gap_en           = 1'b0;
        stall_en         = 1'b0;
        long_hold        = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // unity proportional gain: output bounds and sample extremes
        set_gains(16'h0100, 16'h0000, 16'h0000, 16'h0001);
        send_error(16'd0);
        send_error(16'd999);
        send_error(16'd1000);
        send_error(16'd1001);
        send_error(16'h7FFF);
        send_error(16'h8000);
        send_error(16'hFFFF);
        send_error(16'd1);

        // zero rate: no integral division, no derivative
        set_gains(16'h0000, 16'h7FFF, 16'h8000, 16'h0000);
        send_error(16'h7FFF);
        send_error(16'h8000);
        send_error(16'd5);
        send_error(-16'sd5);

        // extreme gains and the largest rate
        set_gains(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_error(16'h8000);
        send_error(16'h7FFF);
        send_error(16'd0);
        send_error(16'hFFFF);

        // derivative alone: step up, hold, step down
        set_gains(16'h0000, 16'h0000, 16'h0100, 16'h0001);
        send_error(16'd0);
        send_error(16'd300);
        send_error(16'd300);
        send_error(16'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            mode = ph % 4;
            case ($urandom_range(0, 5))
                0: r = 16'h0000;
                1: r = 16'h0001;
                2: r = 16'hFFFF;
                3: r = 16'($urandom);
                default: r = 16'($urandom_range(1, 64));
            endcase
            if (mode == 2) begin
                // small integral gain and slow rate keep the integral visible
                set_gains(16'($urandom_range(0, 63) - 32), 16'($urandom_range(1, 16)),
                          16'h0000, 16'($urandom_range(256, 4096)));
            end else begin
                set_gains(pick_gain(), pick_gain(), pick_gain(), r);
            end

            gap_en   = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            stall_en = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (ph == 5) begin
                // keep offering samples while results are held back
                gap_en    = 1'b0;
                long_hold = 1'b1;
            end
            dir = 1'($urandom_range(0, 1));

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (mode == 3) begin
                    mode = 4 + $urandom_range(0, 2);
                end
                case (mode)
                    0, 4: err = 16'($urandom);
                    1, 5: err = 16'($urandom_range(0, 255) - 128);
                    default: begin
                        // wind the integral into its clamp, then back off
                        if (k == 130) begin
                            dir = ~dir;
                        end
                        if ($urandom_range(0, 7) == 0) begin
                            err = dir ? 16'($urandom_range(0, 32767))
                                      : 16'(-$urandom_range(1, 32768));
                        end else begin
                            err = dir ? 16'h7FFF : 16'h8000;
                        end
                    end
                endcase
                if (ph % 4 == 3) begin
                    mode = 3;
                end
                send_error(err);
            end
        end

        gap_en   = 1'b0;
        stall_en = 1'b0;
        wait_idle();
        if (fail_cnt == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
